[sv/scatter_reduce_rows_assert.svh]
// assertion macros for the checker file of scatter_reduce_rows
// no dependencies; take in by `include inside a module body
`ifndef SCATTER_REDUCE_ROWS_ASSERT_SVH
`define SCATTER_REDUCE_ROWS_ASSERT_SVH

// same-cycle implication, off during reset
`define SRR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also watches the reset cycles
`define SRR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/srr_pkg.sv]
// shared types, constants and register map of the scatter-reduce table
// no dependencies; used by every module of scatter_reduce_rows but srr_ram
`default_nettype none

package srr_pkg;

  localparam int unsigned ROW_W = 10;
  localparam int unsigned COL_W = 4;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned REQ_W = 2;

  localparam int unsigned MAX_ROWS_DEF = 1024;
  localparam int unsigned MAX_COLS_DEF = 16;

  // epoch tag kept next to each table word; tag 0 means never written
  localparam int unsigned EPOCH_W = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

  // register map
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  localparam logic [10:0] ROWS_RESET = 11'd1024;
  localparam logic [4:0]  COLS_RESET = 5'd16;

  localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MOST_POS = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] update_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic                    status;
  } out_item_t;

  // classified request passed from the front end to the back end
  typedef struct packed {
    logic [REQ_W-1:0]        kind;
    logic                    range_err;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] update_value;
  } cmd_t;

  // queue and sweep status seen by the front end
  typedef struct packed {
    logic full;
    logic sweeping;
  } front_ctl_t;

endpackage

`default_nettype wire

[sv/srr_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module srr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/srr_front.sv]
// front end: accepts requests, range-checks them and pushes commands
// depends on srr_pkg
`default_nettype none

module srr_front #(
  parameter int unsigned MAX_ROWS = srr_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = srr_pkg::MAX_COLS_DEF
) (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire srr_pkg::in_item_t  in_data,
  input  wire logic [10:0]        row_count,
  input  wire logic [4:0]         row_width,
  input  wire srr_pkg::front_ctl_t ctl,
  output logic                    push,
  output srr_pkg::cmd_t           push_cmd
);
  import srr_pkg::*;

  logic row_ok;
  logic col_ok;
  logic indexed;

  assign row_ok = ({1'b0, in_data.row_index} < row_count) &&
                  (32'(in_data.row_index) < 32'(MAX_ROWS));
  assign col_ok = ({1'b0, in_data.col_index} < row_width) &&
                  (32'(in_data.col_index) < 32'(MAX_COLS));
  assign indexed = (in_data.req_type == REQ_UPDATE) || (in_data.req_type == REQ_READ);

  assign in_stall = ctl.full || ctl.sweeping;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_cmd.kind         = in_data.req_type;
    push_cmd.range_err    = indexed && !(row_ok && col_ok);
    push_cmd.row_index    = in_data.row_index;
    push_cmd.col_index    = in_data.col_index;
    push_cmd.update_value = in_data.update_value;
  end

endmodule

`default_nettype wire

[sv/srr_queue.sv]
// two-entry command queue between front end and back end
// depends on srr_pkg
`default_nettype none

module srr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire srr_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output srr_pkg::cmd_t      q_cmd
);
  import srr_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[sv/srr_back.sv]
// back end: table memory with epoch tags, read-modify-write and result register
// depends on srr_pkg and srr_ram
`default_nettype none

module srr_back #(
  parameter int unsigned MAX_ROWS = srr_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = srr_pkg::MAX_COLS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           reduce_mode,
  input  wire logic           q_valid,
  input  wire srr_pkg::cmd_t  q_cmd,
  output logic                pop,
  output logic                sweeping,
  output logic                out_valid,
  input  wire logic           out_stall,
  output srr_pkg::out_item_t  out_data
);
  import srr_pkg::*;

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WORD_W = EPOCH_W + VAL_W;

  localparam logic [1:0] B_SWEEP = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_EXEC  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [ADDR_W-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // command held while its table word is read
  logic [ADDR_W-1:0]       cur_addr_r, cur_addr_nxt;
  logic [REQ_W-1:0]        cur_kind_r, cur_kind_nxt;
  logic signed [VAL_W-1:0] cur_value_r, cur_value_nxt;

  logic                    out_free;
  logic                    out_load;
  logic                    needs_ram;
  logic [ADDR_W-1:0]       q_addr;
  logic                    wr_en, rd_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [WORD_W-1:0]       wr_data, rd_data;
  logic [EPOCH_W-1:0]      stored_tag;
  logic signed [VAL_W-1:0] stored_val, old_val, max_val, sat_val, new_val;
  logic [VAL_W:0]          sum_ext;

  srr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(q_addr),
    .rd_data(rd_data)
  );

  assign q_addr = ADDR_W'(32'(q_cmd.row_index) * 32'(MAX_COLS) + 32'(q_cmd.col_index));
  assign needs_ram = ((q_cmd.kind == REQ_UPDATE) || (q_cmd.kind == REQ_READ)) &&
                     !q_cmd.range_err;
  assign out_free = !out_valid_r || !out_stall;

  // an entry counts as written only when its tag matches the current epoch
  assign stored_tag = rd_data[WORD_W-1 -: EPOCH_W];
  assign stored_val = signed'(rd_data[VAL_W-1:0]);
  assign old_val = (stored_tag == epoch_r) ? stored_val :
                   (reduce_mode ? VAL_MOST_NEG : '0);
  assign sum_ext = {old_val[VAL_W-1], old_val} + {cur_value_r[VAL_W-1], cur_value_r};
  assign sat_val = (sum_ext[VAL_W] != sum_ext[VAL_W-1]) ?
                   (sum_ext[VAL_W] ? VAL_MOST_NEG : VAL_MOST_POS) :
                   signed'(sum_ext[VAL_W-1:0]);
  assign max_val = (cur_value_r > old_val) ? cur_value_r : old_val;
  assign new_val = reduce_mode ? max_val : sat_val;

  always_comb begin
    state_nxt      = state_r;
    epoch_nxt      = epoch_r;
    sweep_addr_nxt = sweep_addr_r;
    cur_addr_nxt   = cur_addr_r;
    cur_kind_nxt   = cur_kind_r;
    cur_value_nxt  = cur_value_r;
    out_load       = 1'b0;
    out_item_nxt   = out_item_r;
    pop            = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = cur_addr_r;
    wr_data        = {epoch_r, new_val};

    unique case (state_r)
      B_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_addr_r;
        wr_data = '0;
        if (sweep_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
        end
      end
      B_IDLE: begin
        if (q_valid && needs_ram) begin
          pop           = 1'b1;
          rd_en         = 1'b1;
          cur_addr_nxt  = q_addr;
          cur_kind_nxt  = q_cmd.kind;
          cur_value_nxt = q_cmd.update_value;
          state_nxt     = B_EXEC;
        end else if (q_valid && out_free) begin
          pop                      = 1'b1;
          out_load                 = 1'b1;
          out_item_nxt.entry_value = '0;
          out_item_nxt.status      = q_cmd.range_err;
          if (q_cmd.kind == REQ_CLEAR) begin
            // epoch wrap: tags must be swept back to zero
            if (epoch_r == '1) begin
              epoch_nxt      = EPOCH_W'(1);
              sweep_addr_nxt = '0;
              state_nxt      = B_SWEEP;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
          end
        end
      end
      B_EXEC: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_item_nxt.status = 1'b0;
          if (cur_kind_r == REQ_UPDATE) begin
            wr_en                    = 1'b1;
            out_item_nxt.entry_value = new_val;
          end else begin
            out_item_nxt.entry_value = old_val;
          end
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_SWEEP;
      epoch_r      <= EPOCH_W'(1);
      sweep_addr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_addr_r  <= cur_addr_nxt;
    cur_kind_r  <= cur_kind_nxt;
    cur_value_r <= cur_value_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign sweeping  = (state_r == B_SWEEP);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

[sv/scatter_reduce_rows.sv]
// scatter-reduce table: update and read requests go through the back end's idle
// and exec states, clear and rejected ones through idle only, and each waits on a
// stalled result; results pass the queue slot, the table ram read (update and read
// only) and the result register. reset (synchronous, active low) clears control
// state, then a tag sweep of all MAX_ROWS*MAX_COLS table words holds in_stall
// high; the same sweep runs after every 255th clear request
`default_nettype none

module scatter_reduce_rows #(
  parameter int unsigned MAX_ROWS = srr_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = srr_pkg::MAX_COLS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire srr_pkg::in_item_t                   in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output srr_pkg::out_item_t                       out_data,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [srr_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [srr_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                     pready
);
  import srr_pkg::*;

  // configuration registers
  logic        reduce_mode_r, reduce_mode_nxt;
  logic [10:0] row_count_r, row_count_nxt;
  logic [4:0]  row_width_r, row_width_nxt;
  logic        cfg_write;

  // front to queue to back
  front_ctl_t front_ctl;
  logic       push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       pop;
  logic       sweeping;

  // register port: zero wait states, word index in paddr[3:2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    reduce_mode_nxt = reduce_mode_r;
    row_count_nxt   = row_count_r;
    row_width_nxt   = row_width_r;
    if (cfg_write) begin
      unique case (paddr[3:2])
        REG_MODE: reduce_mode_nxt = pwdata[0];
        REG_ROWS: row_count_nxt   = pwdata[10:0];
        REG_COLS: row_width_nxt   = pwdata[4:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE: prdata = CFG_DATA_W'(reduce_mode_r);
      REG_ROWS: prdata = CFG_DATA_W'(row_count_r);
      REG_COLS: prdata = CFG_DATA_W'(row_width_r);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reduce_mode_r <= 1'b0;
      row_count_r   <= ROWS_RESET;
      row_width_r   <= COLS_RESET;
    end else begin
      reduce_mode_r <= reduce_mode_nxt;
      row_count_r   <= row_count_nxt;
      row_width_r   <= row_width_nxt;
    end
  end

  // the front end stops taking transfers while the queue is full or the
  // tags are being swept
  assign front_ctl.full     = q_full;
  assign front_ctl.sweeping = sweeping;

  srr_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .row_count(row_count_r),
    .row_width(row_width_r),
    .ctl      (front_ctl),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples request intake from the table access
  srr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  // table access, reduction and result register
  srr_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .reduce_mode(reduce_mode_r),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .sweeping   (sweeping),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

[sv/srr_checker.sv]
// port-level assertions for scatter_reduce_rows, bound to the top level
// depends on srr_pkg and scatter_reduce_rows_assert.svh
`default_nettype none

module srr_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire srr_pkg::out_item_t                 out_data,
  input wire logic                               psel,
  input wire logic                               penable,
  input wire logic                               pwrite,
  input wire logic                               pready,
  input wire logic [srr_pkg::CFG_ADDR_W-1:0]     paddr,
  input wire logic [srr_pkg::CFG_DATA_W-1:0]     pwdata,
  input wire logic [srr_pkg::CFG_DATA_W-1:0]     prdata
);
  import srr_pkg::*;
  `include "scatter_reduce_rows_assert.svh"

  // a stalled result stays offered
  `SRR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `SRR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "stalled result changed")

  // after reset no result is offered and the tag sweep holds off requests
  `SRR_ASSERT_NEXT_ALWAYS(a_reset, clk, !rst_n, in_stall && !out_valid, "reset state wrong")

  // a mode write reads back on the next cycle at the same address
  `SRR_ASSERT_NEXT(a_mode_rb, clk, rst_n, psel && penable && pwrite && pready && paddr[3:2] == REG_MODE, paddr != $past(paddr) || prdata[0] == $past(pwdata[0]), "mode readback wrong")

endmodule

bind scatter_reduce_rows srr_checker u_srr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .pready   (pready),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

`default_nettype wire
